// ===== rtl/core/buck_voltage_pi_with_current_limit_assert.svh =====
`ifndef BUCK_VOLTAGE_PI_WITH_CURRENT_LIMIT_ASSERT_SVH
`define BUCK_VOLTAGE_PI_WITH_CURRENT_LIMIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BVPI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bvpi assertion failed");

// Next-cycle implication, disabled during reset.
`define BVPI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bvpi assertion failed");

`endif

// ===== rtl/core/bvpi_pkg.sv =====
package bvpi_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_VOUT_CAL_GAIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOUT_CAL_OFFSET = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VOLTAGE_REF     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_LIMIT   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY        = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DUTY        = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PERIOD      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BOOST_DUTY      = 4'd7;

   localparam logic [15:0] RST_VOUT_CAL_GAIN = 16'd4096;
   localparam logic [11:0] RST_CURRENT_LIMIT = 12'd4095;
   localparam logic [11:0] RST_MAX_DUTY      = 12'd3686;
   localparam logic [11:0] RST_BOOST_DUTY    = 12'd3809;

   localparam int ACC_W   = 32;
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = 30;
   localparam int CINT_W  = 25;
   localparam int VERR_W  = 24;

   localparam int I_KP      = 5;
   localparam int V_KP      = 50;
   localparam int V_KI      = 5;
   localparam int V_INT_MIN = 327680;
   localparam int I_INT_MIN = -123400;
   localparam int I_INT_MAX = 11840000;

   typedef struct packed {
      logic [15:0]        vout_cal_gain;
      logic signed [12:0] vout_cal_offset;
      logic [15:0]        voltage_ref;
      logic [11:0]        current_limit;
      logic [11:0]        max_duty;
      logic [11:0]        min_duty;
      logic [15:0]        pwm_period;
      logic [11:0]        boost_duty;
   } cfg_type;

endpackage

// ===== rtl/core/bvpi_csr.sv =====
module bvpi_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [bvpi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bvpi_pkg::CSR_DATA_W-1:0]  csr_data,
   output bvpi_pkg::cfg_type                cfg
);

   bvpi_pkg::cfg_type cfg_ff;
   bvpi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bvpi_pkg::REG_VOUT_CAL_GAIN:   cfg_in.vout_cal_gain   = csr_data;
            bvpi_pkg::REG_VOUT_CAL_OFFSET: cfg_in.vout_cal_offset = $signed(csr_data[12:0]);
            bvpi_pkg::REG_VOLTAGE_REF:     cfg_in.voltage_ref     = csr_data;
            bvpi_pkg::REG_CURRENT_LIMIT:   cfg_in.current_limit   = csr_data[11:0];
            bvpi_pkg::REG_MAX_DUTY:        cfg_in.max_duty        = csr_data[11:0];
            bvpi_pkg::REG_MIN_DUTY:        cfg_in.min_duty        = csr_data[11:0];
            bvpi_pkg::REG_PWM_PERIOD:      cfg_in.pwm_period      = csr_data;
            bvpi_pkg::REG_BOOST_DUTY:      cfg_in.boost_duty      = csr_data[11:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vout_cal_gain   <= bvpi_pkg::RST_VOUT_CAL_GAIN;
         cfg_ff.vout_cal_offset <= '0;
         cfg_ff.voltage_ref     <= '0;
         cfg_ff.current_limit   <= bvpi_pkg::RST_CURRENT_LIMIT;
         cfg_ff.max_duty        <= bvpi_pkg::RST_MAX_DUTY;
         cfg_ff.min_duty        <= '0;
         cfg_ff.pwm_period      <= '0;
         cfg_ff.boost_duty      <= bvpi_pkg::RST_BOOST_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/bvpi_mul.sv =====
module bvpi_mul (
   input  logic                                clock,
   input  logic signed [bvpi_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [bvpi_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [bvpi_pkg::PROD_W-1:0]  prod_ff
);

   localparam int FULL_W = bvpi_pkg::MUL_A_W + bvpi_pkg::MUL_B_W;

   logic signed [FULL_W-1:0]          full;
   logic signed [bvpi_pkg::PROD_W-1:0] prod_in;

   assign full    = mul_a * mul_b;
   assign prod_in = $signed(full[bvpi_pkg::PROD_W-1:0]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/buck_voltage_pi_with_current_limit.sv =====
// Each accepted item steps through states I1, I2, V1 to V4, C1 and C2.
// New items are taken only in idle, and C2 waits while a result is unaccepted.
// All multiplications go one per cycle through a single shared multiplier.
// Reset clears both loop integrators, the limit correction and the sequencer,
// and loads every configuration register with its default value.
`include "buck_voltage_pi_with_current_limit_assert.svh"

module buck_voltage_pi_with_current_limit #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [11:0]                      req_vout_sample,
   input  logic [11:0]                      req_iout_average,
   input  logic                             req_pwm_enable,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [11:0]                      rsp_buck_duty,
   output logic [15:0]                      rsp_buck_compare,
   output logic [14:0]                      rsp_buck_mid_compare,
   output logic [15:0]                      rsp_boost_compare,
   output logic [11:0]                      rsp_limit_correction,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bvpi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bvpi_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW     = bvpi_pkg::ACC_W;
   localparam int MA     = bvpi_pkg::MUL_A_W;
   localparam int MB     = bvpi_pkg::MUL_B_W;
   localparam int PW     = bvpi_pkg::PROD_W;
   localparam int CW     = bvpi_pkg::CINT_W;
   localparam int VW     = bvpi_pkg::VERR_W;
   localparam int LIM_W  = 24 - FRACTION_BITS;
   localparam int VINT_W = 12 + FRACTION_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_I1   = 4'd1;
   localparam logic [3:0] S_I2   = 4'd2;
   localparam logic [3:0] S_V1   = 4'd3;
   localparam logic [3:0] S_V2   = 4'd4;
   localparam logic [3:0] S_V3   = 4'd5;
   localparam logic [3:0] S_V4   = 4'd6;
   localparam logic [3:0] S_C1   = 4'd7;
   localparam logic [3:0] S_C2   = 4'd8;

   localparam logic signed [AW-1:0] I_LO  = AW'(bvpi_pkg::I_INT_MIN);
   localparam logic signed [AW-1:0] I_HI  = AW'(bvpi_pkg::I_INT_MAX);
   localparam logic signed [AW-1:0] V_LO  = AW'(bvpi_pkg::V_INT_MIN);
   localparam logic signed [CW-1:0] CINT_LO = CW'(bvpi_pkg::I_INT_MIN);
   localparam logic signed [CW-1:0] CINT_HI = CW'(bvpi_pkg::I_INT_MAX);

   bvpi_pkg::cfg_type cfg;

   logic [3:0]              state_ff, state_in;
   logic [11:0]             vs_ff, ia_ff;
   logic                    en_ff;
   logic signed [CW-1:0]    cint_ff, cint_in;
   logic [VINT_W-1:0]       vint_ff, vint_in;
   logic [LIM_W-1:0]        limit_ff, limit_in;
   logic [11:0]             llc_ff, llc_in;
   logic signed [VW-1:0]    verr_ff;
   logic [11:0]             duty_ff, duty_in;
   logic [15:0]             bcmp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [11:0]             rsp_duty_ff, rsp_lim_ff;
   logic [15:0]             rsp_bcmp_ff, rsp_bst_ff;

   logic signed [MA-1:0]    mul_a;
   logic signed [MB-1:0]    mul_b;
   logic signed [PW-1:0]    prod_ff;

   logic                    accept, out_free;
   logic signed [12:0]      ierr;
   logic signed [AW-1:0]    iout, iout_sh, csum, c1, c2;
   logic [AW-1:0]           lim_ext;
   logic signed [AW-1:0]    prod_sh, vcal, verr_full;
   logic signed [AW-1:0]    vsum, dsh, max_s, min_s, vmax_s, d1, d2, vt1, vt2;

   bvpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bvpi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_I1: begin
            mul_a = MA'(ierr);
            mul_b = MB'(bvpi_pkg::I_KP);
         end
         S_I2: begin
            mul_a = MA'({1'b0, vs_ff});
            mul_b = {1'b0, cfg.vout_cal_gain};
         end
         S_V2: begin
            mul_a = MA'(verr_ff);
            mul_b = MB'(bvpi_pkg::V_KP);
         end
         S_V3: begin
            mul_a = MA'(verr_ff);
            mul_b = MB'(bvpi_pkg::V_KI);
         end
         S_V4: begin
            mul_a = MA'({1'b0, duty_ff});
            mul_b = {1'b0, cfg.pwm_period};
         end
         S_C1: begin
            mul_a = MA'({1'b0, cfg.boost_duty});
            mul_b = {1'b0, cfg.pwm_period};
         end
         S_C2: begin
            mul_a = MA'({1'b0, cfg.boost_duty});
            mul_b = {1'b0, cfg.pwm_period};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign ierr     = $signed({1'b0, ia_ff}) - $signed({1'b0, cfg.current_limit});
   assign iout     = AW'(cint_ff) + AW'(prod_ff);
   assign iout_sh  = iout >>> FRACTION_BITS;
   assign limit_in = (iout < 0) ? '0 : iout_sh[LIM_W-1:0];
   assign lim_ext  = AW'(limit_in);
   assign llc_in   = lim_ext[11:0];
   assign csum     = AW'(cint_ff) + AW'(ierr);
   assign c1       = (csum < I_LO) ? I_LO : csum;
   assign c2       = (c1 > I_HI) ? I_HI : c1;
   assign cint_in  = $signed(c2[CW-1:0]);

   assign prod_sh   = AW'(prod_ff) >>> FRACTION_BITS;
   assign vcal      = prod_sh + AW'(cfg.vout_cal_offset);
   assign verr_full = AW'(cfg.voltage_ref) - vcal - AW'(limit_ff);

   assign vsum   = AW'(vint_ff) + AW'(prod_ff);
   assign dsh    = vsum >>> FRACTION_BITS;
   assign max_s  = AW'(cfg.max_duty);
   assign min_s  = AW'(cfg.min_duty);
   assign vmax_s = max_s <<< FRACTION_BITS;
   assign d1     = (dsh > max_s) ? max_s : dsh;
   assign d2     = (d1 < min_s) ? min_s : d1;
   assign duty_in = en_ff ? d2[11:0] : cfg.min_duty;
   assign vt1    = (vsum < V_LO) ? V_LO : vsum;
   assign vt2    = (vt1 > vmax_s) ? vmax_s : vt1;
   assign vint_in = vt2[VINT_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_I1;
         S_I1:    state_in = S_I2;
         S_I2:    state_in = S_V1;
         S_V1:    state_in = S_V2;
         S_V2:    state_in = S_V3;
         S_V3:    state_in = S_V4;
         S_V4:    state_in = S_C1;
         S_C1:    state_in = S_C2;
         S_C2:    if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || ((state_ff == S_C2) && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cint_ff      <= '0;
         vint_ff      <= '0;
         limit_ff     <= '0;
         llc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_I2) begin
            cint_ff  <= cint_in;
            limit_ff <= limit_in;
            llc_ff   <= llc_in;
         end
         if (state_ff == S_V4) begin
            vint_ff <= vint_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vs_ff <= req_vout_sample;
         ia_ff <= req_iout_average;
         en_ff <= req_pwm_enable;
      end
      if (state_ff == S_V1) begin
         verr_ff <= $signed(verr_full[VW-1:0]);
      end
      if (state_ff == S_V3) begin
         duty_ff <= duty_in;
      end
      if (state_ff == S_C1) begin
         bcmp_ff <= prod_sh[15:0];
      end
      if ((state_ff == S_C2) && out_free) begin
         rsp_duty_ff <= duty_ff;
         rsp_bcmp_ff <= bcmp_ff;
         rsp_bst_ff  <= cfg.pwm_period - prod_sh[15:0];
         rsp_lim_ff  <= llc_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_buck_duty        = rsp_duty_ff;
   assign rsp_buck_compare     = rsp_bcmp_ff;
   assign rsp_buck_mid_compare = rsp_bcmp_ff[15:1];
   assign rsp_boost_compare    = rsp_bst_ff;
   assign rsp_limit_correction = rsp_lim_ff;

   `BVPI_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `BVPI_ASSERT_IMP(a_duty_above_min, clock, reset, rsp_valid, rsp_buck_duty >= cfg.min_duty)
   `BVPI_ASSERT_IMP(a_cint_in_range, clock, reset, 1'b1, (cint_ff >= CINT_LO) && (cint_ff <= CINT_HI))

endmodule

// ===== dv/testbench.sv =====
module testbench;

   localparam int FRAC = 12;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 11;
   localparam int TICKS_PER_PHASE = 58;

   localparam longint CUR_KP = 5;
   localparam longint CUR_KI = 1;
   localparam longint CUR_INT_LO = -123400;
   localparam longint CUR_INT_HI = 11840000;
   localparam longint VLT_KP = 50;
   localparam longint VLT_KI = 5;
   localparam longint VLT_INT_LO = 327680;

   typedef struct packed {
      logic [11:0] buck_duty;
      logic [15:0] buck_compare;
      logic [14:0] buck_mid_compare;
      logic [15:0] boost_compare;
      logic [11:0] limit_correction;
   } tick_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [11:0]                     req_vout_sample = '0;
   logic [11:0]                     req_iout_average = '0;
   logic                            req_pwm_enable = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [11:0]                     rsp_buck_duty;
   logic [15:0]                     rsp_buck_compare;
   logic [14:0]                     rsp_buck_mid_compare;
   logic [15:0]                     rsp_boost_compare;
   logic [11:0]                     rsp_limit_correction;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [bvpi_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bvpi_pkg::CSR_DATA_W-1:0] csr_data = '0;

   bvpi_pkg::cfg_type regs_model;
   longint            volt_integ;
   longint            cur_integ;
   tick_result_type   pending_ticks[$];

   int mismatch_count = 0;
   int ticks_sent = 0;
   int ticks_checked = 0;
   int csr_writes = 0;
   int phases_run = 0;
   int idle_pct = 15;
   int stall_pct = 15;

   buck_voltage_pi_with_current_limit #(
      .FRACTION_BITS(FRAC)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_vout_sample(req_vout_sample),
      .req_iout_average(req_iout_average),
      .req_pwm_enable(req_pwm_enable),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_buck_duty(rsp_buck_duty),
      .rsp_buck_compare(rsp_buck_compare),
      .rsp_buck_mid_compare(rsp_buck_mid_compare),
      .rsp_boost_compare(rsp_boost_compare),
      .rsp_limit_correction(rsp_limit_correction),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic tick_result_type predict_tick(input logic [11:0] vsample,
                                                    input logic [11:0] iavg,
                                                    input logic en);
      tick_result_type r;
      longint ierr, iloop, corr, vcal, verr, vloop, vceil, duty;
      longint per, bcmp, bon, bst;
      ierr = longint'(iavg) - longint'(regs_model.current_limit);
      iloop = cur_integ + ierr * CUR_KP;
      cur_integ = cur_integ + ierr * CUR_KI;
      if (cur_integ < CUR_INT_LO) cur_integ = CUR_INT_LO;
      if (cur_integ > CUR_INT_HI) cur_integ = CUR_INT_HI;
      if (iloop < 0) iloop = 0;
      corr = iloop >>> FRAC;

      vcal = ((longint'(vsample) * longint'(regs_model.vout_cal_gain)) >>> FRAC)
             + longint'($signed(regs_model.vout_cal_offset));
      verr = longint'(regs_model.voltage_ref) - vcal - corr;
      vloop = volt_integ + verr * VLT_KP;
      vceil = longint'(regs_model.max_duty) <<< FRAC;
      volt_integ = volt_integ + verr * VLT_KI;
      if (volt_integ < VLT_INT_LO) volt_integ = VLT_INT_LO;
      if (volt_integ > vceil) volt_integ = vceil;

      duty = vloop >>> FRAC;
      if (duty > longint'(regs_model.max_duty)) duty = longint'(regs_model.max_duty);
      if (duty < longint'(regs_model.min_duty)) duty = longint'(regs_model.min_duty);
      if (!en) duty = longint'(regs_model.min_duty);

      per = longint'(regs_model.pwm_period);
      bcmp = (duty * per) >>> FRAC;
      bon = (longint'(regs_model.boost_duty) * per) >>> FRAC;
      bst = per - bon;

      r.buck_duty = duty[11:0];
      r.buck_compare = bcmp[15:0];
      r.buck_mid_compare = bcmp[15:1];
      r.boost_compare = bst[15:0];
      r.limit_correction = corr[11:0];
      return r;
   endfunction

   function automatic void write_model_reg(input logic [bvpi_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [bvpi_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bvpi_pkg::REG_VOUT_CAL_GAIN:   regs_model.vout_cal_gain = data;
         bvpi_pkg::REG_VOUT_CAL_OFFSET: regs_model.vout_cal_offset = data[12:0];
         bvpi_pkg::REG_VOLTAGE_REF:     regs_model.voltage_ref = data;
         bvpi_pkg::REG_CURRENT_LIMIT:   regs_model.current_limit = data[11:0];
         bvpi_pkg::REG_MAX_DUTY:        regs_model.max_duty = data[11:0];
         bvpi_pkg::REG_MIN_DUTY:        regs_model.min_duty = data[11:0];
         bvpi_pkg::REG_PWM_PERIOD:      regs_model.pwm_period = data;
         bvpi_pkg::REG_BOOST_DUTY:      regs_model.boost_duty = data[11:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : scoreboard
      tick_result_type got;
      tick_result_type want;
      bit orphan;
      if (reset) begin
         regs_model = '{vout_cal_gain: 16'd4096, vout_cal_offset: '0, voltage_ref: '0,
                        current_limit: 12'd4095, max_duty: 12'd3686, min_duty: '0,
                        pwm_period: '0, boost_duty: 12'd3809};
         volt_integ = 0;
         cur_integ = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_buck_duty, rsp_buck_compare, rsp_buck_mid_compare,
                    rsp_boost_compare, rsp_limit_correction};
            ticks_checked++;
            orphan = (pending_ticks.size() == 0);
            want = 'x;
            if (!orphan) want = pending_ticks.pop_front();
            if (orphan || got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result mismatch%s", $time, orphan ? " (none expected)" : "");
                  $display("   expected duty %0d cmp %0d mid %0d boost %0d limit %0d",
                           want.buck_duty, want.buck_compare, want.buck_mid_compare,
                           want.boost_compare, want.limit_correction);
                  $display("   actual   duty %0d cmp %0d mid %0d boost %0d limit %0d",
                           got.buck_duty, got.buck_compare, got.buck_mid_compare,
                           got.boost_compare, got.limit_correction);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_ticks.push_back(predict_tick(req_vout_sample, req_iout_average,
                                                 req_pwm_enable));
            ticks_sent++;
         end
         if (csr_valid && csr_ready) begin
            write_model_reg(csr_index, csr_data);
            csr_writes++;
         end
      end
   end

   task automatic send_tick(input logic [11:0] vsample, input logic [11:0] iavg,
                            input logic en);
      if ($urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 20)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_vout_sample <= vsample;
      req_iout_average <= iavg;
      req_pwm_enable <= en;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bvpi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bvpi_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] gain, input logic [15:0] offset,
                            input logic [15:0] vref, input logic [15:0] ilimit,
                            input logic [15:0] dmax, input logic [15:0] dmin,
                            input logic [15:0] period, input logic [15:0] boost);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(bvpi_pkg::REG_VOUT_CAL_GAIN, gain);
      write_reg(bvpi_pkg::REG_VOUT_CAL_OFFSET, offset);
      write_reg(bvpi_pkg::REG_VOLTAGE_REF, vref);
      write_reg(bvpi_pkg::REG_CURRENT_LIMIT, ilimit);
      write_reg(bvpi_pkg::REG_MAX_DUTY, dmax);
      write_reg(bvpi_pkg::REG_MIN_DUTY, dmin);
      write_reg(bvpi_pkg::REG_PWM_PERIOD, period);
      write_reg(bvpi_pkg::REG_BOOST_DUTY, boost);
   endtask

   function automatic logic [15:0] rand_reg(input int width);
      logic [15:0] mask;
      logic [15:0] v;
      mask = 16'((32'd1 << width) - 1);
      v = 16'($urandom);
      case ($urandom_range(5))
         0: v = v & ~mask;
         1: v = v | mask;
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_reset_defaults();
      send_tick(12'd0, 12'd0, 1'b1);
      send_tick(12'd4095, 12'd4095, 1'b1);
      send_tick(12'd2048, 12'd100, 1'b0);
   endtask

   task automatic test_field_extremes();
      configure(16'hFFFF, 16'h1000, 16'hFFFF, 16'd0, 16'd4095, 16'd0, 16'hFFFF, 16'd4095);
      send_tick(12'd0, 12'd0, 1'b1);
      send_tick(12'd4095, 12'd0, 1'b1);
      send_tick(12'd4095, 12'd4095, 1'b1);
      send_tick(12'd0, 12'd4095, 1'b1);
      send_tick(12'd0, 12'd4095, 1'b0);
      send_tick(12'd4095, 12'd4095, 1'b0);
      send_tick(12'd2048, 12'd2048, 1'b1);
      configure(16'd0, 16'h0FFF, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(12'd4095, 12'd0, 1'b1);
      send_tick(12'd0, 12'd4095, 1'b1);
   endtask

   task automatic test_clamp_corners();
      // The duty ceiling sits below the integrator floor.
      configure(16'd4096, 16'd0, 16'd3000, 16'd1000, 16'd10, 16'd0, 16'd40000, 16'd2048);
      repeat (3) send_tick(12'd1000, 12'd3000, 1'b1);
      // A large negative error drives the loop output below zero.
      configure(16'hFFFF, 16'd0, 16'd0, 16'd4095, 16'd3686, 16'd0, 16'd1000, 16'd3809);
      repeat (2) send_tick(12'd4095, 12'd0, 1'b1);
      // The minimum duty is above the maximum.
      configure(16'd4096, 16'd0, 16'd4000, 16'd4095, 16'd500, 16'd3000, 16'd50000, 16'd100);
      send_tick(12'd100, 12'd0, 1'b1);
      send_tick(12'd100, 12'd0, 1'b0);
   endtask

   task automatic test_csr_decode();
      configure(16'hABCD, 16'h7FFF, 16'h1234, 16'hF800, 16'hFFFF, 16'h1000, 16'h1234,
                16'hF123);
      write_reg(4'd8, 16'hFFFF);
      write_reg(4'd15, 16'h0000);
      write_reg(4'd10, 16'h5555);
      send_tick(12'd1500, 12'd2100, 1'b1);
      send_tick(12'd2500, 12'd1900, 1'b1);
      send_tick(12'd3500, 12'd2048, 1'b1);
   endtask

   task automatic test_random_regulation();
      int ilimit;
      int iavg;
      logic [11:0] vsample;
      logic [15:0] ilimit_reg;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_pct = (phase == 4) ? 0 : 15;
         stall_pct = (phase == 4) ? 0 : 15;
         if (phase == 0) begin
            ilimit_reg = 16'hFFFF;
            configure(16'hFFFF, 16'h0FFF, 16'hFFFF, ilimit_reg, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF);
         end else if (phase == 1) begin
            ilimit_reg = 16'h0000;
            configure(16'h0000, 16'h0000, 16'h0000, ilimit_reg, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000);
         end else if (phase % 2 == 1) begin
            ilimit_reg = 16'($urandom_range(500, 3500));
            configure(16'($urandom_range(3500, 4700)), 16'($urandom_range(0, 400) - 200),
                      16'($urandom_range(500, 4000)), ilimit_reg,
                      16'($urandom_range(2000, 4095)), 16'($urandom_range(0, 300)),
                      16'($urandom), 16'($urandom_range(0, 4095)));
         end else begin
            ilimit_reg = rand_reg(12);
            configure(rand_reg(16), rand_reg(13), rand_reg(16), ilimit_reg, rand_reg(12),
                      rand_reg(12), rand_reg(16), rand_reg(12));
         end
         ilimit = int'(ilimit_reg[11:0]);
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            if ($urandom_range(3) == 0) vsample = $urandom_range(1) ? 12'hFFF : 12'h000;
            else vsample = 12'($urandom_range(0, 4095));
            case ($urandom_range(2))
               0: iavg = int'($urandom_range(0, 4095));
               1: iavg = ilimit + int'($urandom_range(0, 600)) - 300;
               default: iavg = $urandom_range(1) ? 4095 : 0;
            endcase
            if (iavg < 0) iavg = 0;
            if (iavg > 4095) iavg = 4095;
            send_tick(vsample, 12'(iavg), $urandom_range(9) != 0);
            if (phase == 6 && i == TICKS_PER_PHASE / 2) hold_until_drained();
         end
         phases_run++;
      end
      idle_pct = 15;
      stall_pct = 15;
   endtask

   initial begin
      int leftover;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_field_extremes();
      test_clamp_corners();
      test_csr_decode();
      test_random_regulation();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 2000 && pending_ticks.size() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      leftover = pending_ticks.size();
      mismatch_count += leftover;
      $display("Sent %0d ticks through %0d register writes and %0d random phases.",
               ticks_sent, csr_writes, phases_run);
      $display("Checked %0d results, %0d mismatches, %0d results never arrived.",
               ticks_checked, mismatch_count - leftover, leftover);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out.");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bvpi_pkg.sv
rtl/core/bvpi_csr.sv
rtl/core/bvpi_mul.sv
rtl/core/buck_voltage_pi_with_current_limit.sv
dv/testbench.sv
